### rtl/gfe_pkg.sv
// Shared types, constants and elaboration-time exp helpers for the Gaussian evaluator.
package gfe_pkg;

  // Default number of exp table intervals
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

  // Quotient bits of t = d^2 / (2 * spread); t at or above 2^20 (16.0) gives zero
  localparam int unsigned QUOT_W = 20;
  // Exp fraction: 0 .. 65536 inclusive
  localparam int unsigned EXP_W = 17;
  // Number of series terms used when the table is built
  localparam int unsigned SERIES_TERMS = 20;

  // Spread that replaces a zero or negative spread write, and the divisor it gives
  localparam int unsigned MIN_SPREAD = 66;
  localparam logic [31:0] DENOM_MIN = 32'(2 * MIN_SPREAD);

  // Register indexes
  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_CENTER    = 2'd1;
  localparam logic [1:0] REG_SPREAD    = 2'd2;

  // Register reset values (divisor register holds 2 * spread)
  localparam logic [31:0] AMPLITUDE_RESET = 32'h0001_0000;
  localparam logic [31:0] CENTER_RESET    = 32'h0000_0000;
  localparam logic [31:0] DENOM_RESET     = 32'h0002_0000;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // Squared distance on its way into the divider
  typedef struct packed {
    logic        valid;
    logic        far;
    logic [63:0] num;
  } div_req_t;

  // Quotient leaving the divider
  typedef struct packed {
    logic              valid;
    logic              far;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Exp fraction leaving the interpolator
  typedef struct packed {
    logic             valid;
    logic [EXP_W-1:0] frac;
  } exp_rsp_t;

  // Divide by a small series index
  function automatic logic [63:0] div_small(logic [63:0] x, logic [4:0] k);
    case (k)
      5'd2:    return x / 64'd2;
      5'd3:    return x / 64'd3;
      5'd4:    return x / 64'd4;
      5'd5:    return x / 64'd5;
      5'd6:    return x / 64'd6;
      5'd7:    return x / 64'd7;
      5'd8:    return x / 64'd8;
      5'd9:    return x / 64'd9;
      5'd10:   return x / 64'd10;
      5'd11:   return x / 64'd11;
      5'd12:   return x / 64'd12;
      5'd13:   return x / 64'd13;
      5'd14:   return x / 64'd14;
      5'd15:   return x / 64'd15;
      5'd16:   return x / 64'd16;
      5'd17:   return x / 64'd17;
      5'd18:   return x / 64'd18;
      5'd19:   return x / 64'd19;
      5'd20:   return x / 64'd20;
      default: return x;
    endcase
  endfunction

  // exp(-f / 65536) in Q0.32 from the truncated alternating series
  function automatic logic [63:0] exp_series(logic [63:0] f);
    logic [63:0] s;
    logic [63:0] term;
    s    = ONE_Q32;
    term = ONE_Q32;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = div_small((term * f) >> 16, 5'(k));
      if (k[0]) begin
        s = (s >= term) ? s - term : 64'd0;
      end else begin
        s = s + term;
      end
    end
    if (s > ONE_Q32) begin
      s = ONE_Q32;
    end
    return s;
  endfunction

  // exp(-a) in Q0.32 for a Q16.16 argument from 0 to 16
  function automatic logic [32:0] exp_value(logic [63:0] a);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] e1;
    logic [63:0] w;
    logic [63:0] s;
    n = a >> 16;
    f = a & 64'h0000_0000_0000_FFFF;
    if (n > 64'd16) begin
      return '0;
    end
    e1 = exp_series(64'd65536);
    if (e1 >= ONE_Q32) begin
      e1 = ONE_Q32 - 64'd1;
    end
    w = ONE_Q32;
    for (int j = 1; j <= 16; j++) begin
      if (64'(j) <= n) begin
        w = (w * e1) >> 32;
      end
    end
    if (f == 64'd0) begin
      return w[32:0];
    end
    s = exp_series(f);
    if (s >= ONE_Q32) begin
      s = ONE_Q32 - 64'd1;
    end
    w = (w * s) >> 32;
    return w[32:0];
  endfunction

endpackage

### rtl/gfe_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage.
module gfe_div_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [31:0]       den_i,
  input  gfe_pkg::div_req_t req_i,
  output gfe_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = gfe_pkg::QUOT_W;

  logic          vld_in [QW];
  logic          lrg_in [QW];
  logic [63:0]   rem_in [QW];
  logic [QW-1:0] quo_in [QW];

  logic [63:0]   rem_d  [QW];
  logic [QW-1:0] quo_d  [QW];

  logic          vld_q  [QW];
  logic          lrg_q  [QW];
  logic [63:0]   rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];

  // Chain each stage onto the one before
  always_comb begin
    vld_in[0] = req_i.valid;
    lrg_in[0] = req_i.far;
    rem_in[0] = req_i.num;
    quo_in[0] = '0;
    for (int s = 1; s < QW; s++) begin
      vld_in[s] = vld_q[s-1];
      lrg_in[s] = lrg_q[s-1];
      rem_in[s] = rem_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
  end

  // Try to take the shifted divisor off the partial remainder
  always_comb begin
    logic [63:0] dsh;
    logic        fits;
    for (int s = 0; s < QW; s++) begin
      dsh      = 64'(den_i) << (QW - 1 - s);
      fits     = (rem_in[s] >= dsh);
      rem_d[s] = fits ? rem_in[s] - dsh : rem_in[s];
      quo_d[s] = quo_in[s] | (QW'(fits) << (QW - 1 - s));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (advance_i) begin
      for (int s = 0; s < QW; s++) begin
        vld_q[s] <= vld_in[s];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int s = 0; s < QW; s++) begin
        lrg_q[s] <= lrg_in[s];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign rsp_o.valid = vld_q[QW-1];
  assign rsp_o.far   = lrg_q[QW-1];
  assign rsp_o.quot  = quo_q[QW-1];

endmodule

### rtl/gfe_exp_interp.sv
// Table-based exp(-t) with linear interpolation, four register stages.
module gfe_exp_interp #(
  parameter int unsigned EXP_TABLE_DEPTH = gfe_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  gfe_pkg::div_rsp_t rsp_i,
  output gfe_pkg::exp_rsp_t exp_o
);

  localparam int unsigned QW    = gfe_pkg::QUOT_W;
  localparam int unsigned EW    = gfe_pkg::EXP_W;
  localparam int unsigned PT_N  = EXP_TABLE_DEPTH + 1;
  localparam int unsigned PT_W  = $clog2(PT_N);
  localparam int unsigned POS_W = QW + PT_W;
  localparam int unsigned MUL_W = 33 + QW;

  // Constant table of exp(-a_k) in Q0.32
  logic [32:0] exp_tab [PT_N];

  for (genvar k = 0; k < PT_N; k++) begin : g_tab
    localparam logic [63:0] ARG =
      ((64'(k) << QW) + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
    localparam logic [32:0] POINT = gfe_pkg::exp_value(ARG);
    assign exp_tab[k] = POINT;
  end

  // Stage A: scale t to a table position
  logic [POS_W-1:0] pos_d;
  logic             va_q, la_q;
  logic [PT_W-1:0]  idx_q;
  logic [QW-1:0]    ra_q;

  assign pos_d = POS_W'(rsp_i.quot) * POS_W'(EXP_TABLE_DEPTH);

  // Stage B: read both neighbors, form their distance
  logic [PT_W-1:0]  idx_nx;
  logic [32:0]      pa, pb;
  logic             vb_q, lb_q, up_q;
  logic [32:0]      ab_q, diff_q;
  logic [QW-1:0]    rb_q;

  assign idx_nx = idx_q + PT_W'(1);
  assign pa     = exp_tab[idx_q];
  assign pb     = exp_tab[idx_nx];

  // Stage C: weight the distance by the position remainder
  logic [MUL_W-1:0] mul_d;
  logic             vc_q, lc_q, uc_q;
  logic [32:0]      ac_q;
  logic [MUL_W-1:0] mul_q;

  assign mul_d = MUL_W'(diff_q) * MUL_W'(rb_q);

  // Stage D: offset, round to Q0.16, zero a large argument
  logic [33:0]   step, v_d, rnd;
  logic [EW-1:0] frac_d;
  logic          vd_q;
  logic [EW-1:0] frac_q;

  assign step   = 34'(mul_q[MUL_W-1:QW]);
  assign v_d    = uc_q ? {1'b0, ac_q} + step : {1'b0, ac_q} - step;
  assign rnd    = v_d + 34'd32768;
  assign frac_d = lc_q ? '0 : rnd[32:16];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (advance_i) begin
      va_q <= rsp_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      la_q   <= rsp_i.far;
      idx_q  <= pos_d[QW +: PT_W];
      ra_q   <= pos_d[QW-1:0];

      lb_q   <= la_q;
      rb_q   <= ra_q;
      ab_q   <= pa;
      up_q   <= (pb > pa);
      diff_q <= (pa >= pb) ? pa - pb : pb - pa;

      lc_q   <= lb_q;
      uc_q   <= up_q;
      ac_q   <= ab_q;
      mul_q  <= mul_d;

      frac_q <= frac_d;
    end
  end

  assign exp_o.valid = vd_q;
  assign exp_o.frac  = frac_q;

endmodule

### rtl/gaussian_function_eval.sv
// Top level: Gaussian curve evaluator, y = amplitude * exp(-(x-center)^2 / (2*spread)).
//
//  Channel  | Direction | Handshake                      | Payload
//  ---------+-----------+--------------------------------+----------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata[31:0] x_value
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata[31:0] y_value
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle while s_axis_tready is high. Most of the pipeline depth lies in
// the 20-stage restoring divider that forms the exp argument.
// Reset restores amplitude 1.0, center 0 and spread 1.0 and empties the pipeline.
// When m_axis_tready is low one more result lands in a skid register; the whole pipeline
// then holds and s_axis_tready drops until that register drains. Config writes are always accepted.
module gaussian_function_eval #(
  parameter int unsigned EXP_TABLE_DEPTH = gfe_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_value

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] y_value

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers
  logic [31:0] amp_q, center_q, denom_q;

  assign cfg_ready_o = 1'b1;

  // Write a register; store the spread as its clamped divisor 2 * spread
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q    <= gfe_pkg::AMPLITUDE_RESET;
      center_q <= gfe_pkg::CENTER_RESET;
      denom_q  <= gfe_pkg::DENOM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gfe_pkg::REG_AMPLITUDE: amp_q <= cfg_data_i;
        gfe_pkg::REG_CENTER:    center_q <= cfg_data_i;
        gfe_pkg::REG_SPREAD: begin
          if (cfg_data_i[31] || cfg_data_i == 32'd0) begin
            denom_q <= gfe_pkg::DENOM_MIN;
          end else begin
            denom_q <= {cfg_data_i[30:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // Pipeline advances while the skid register is empty
  logic skid_valid_q;
  logic adv;

  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;

  // Stage 1: distance from center and its magnitude
  logic [32:0] delta;
  logic [32:0] delta_abs;
  logic        v1_q;
  logic [31:0] mag_q;

  assign delta     = {s_axis_tdata[31], s_axis_tdata} - {center_q[31], center_q};
  assign delta_abs = delta[32] ? (33'd0 - delta) : delta;

  // Stage 2: square
  logic        v2_q;
  logic [63:0] sq_q;

  // Stage 3: flag arguments of 16 and more
  logic              req_vld_q;
  logic              req_far_q;
  logic [63:0]       req_num_q;
  gfe_pkg::div_req_t div_req;
  gfe_pkg::div_rsp_t div_rsp;
  gfe_pkg::exp_rsp_t exp_rsp;

  assign div_req = '{valid: req_vld_q, far: req_far_q, num: req_num_q};

  // Stage 4 after exp: scale by amplitude
  logic signed [31:0] amp_s;
  logic signed [17:0] frac_s;
  logic signed [49:0] prod_d;
  logic               vp_q;
  logic signed [49:0] prod_q;

  assign amp_s  = amp_q;
  assign frac_s = {1'b0, exp_rsp.frac};
  assign prod_d = amp_s * frac_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      req_vld_q <= 1'b0;
      vp_q      <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      req_vld_q <= v2_q;
      vp_q      <= exp_rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q     <= delta_abs[31:0];
      sq_q      <= 64'(mag_q) * 64'(mag_q);
      req_num_q <= sq_q;
      req_far_q <= (sq_q >= {12'd0, denom_q, 20'd0});
      prod_q    <= prod_d;
    end
  end

  gfe_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (adv),
    .den_i     (denom_q),
    .req_i     (div_req),
    .rsp_o     (div_rsp)
  );

  gfe_exp_interp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (adv),
    .rsp_i     (div_rsp),
    .exp_o     (exp_rsp)
  );

  // Round to Q16.16 and saturate
  logic signed [49:0] rnd;
  logic        [33:0] y_wide;
  logic        [31:0] y_d;

  assign rnd    = prod_q + 50'sd32768;
  assign y_wide = rnd[49:16];
  assign y_d    = (y_wide[33:31] == 3'b000 || y_wide[33:31] == 3'b111) ? y_wide[31:0]
                : (y_wide[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // Output register with one skid entry
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [31:0] skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= vp_q;
    end else if (vp_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      if (vp_q) begin
        out_data_q <= y_d;
      end
    end else if (vp_q) begin
      skid_data_q <= y_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
